### sv/alpe_pkg.sv
// ----------------------------------------------------------------------------
// alpe_pkg
// shared types and constants of the led pulse encoder
// ----------------------------------------------------------------------------
package alpe_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_ONE_HIGH    = 3'd0;
	localparam logic [2:0] REG_ZERO_HIGH   = 3'd1;
	localparam logic [2:0] REG_BIT_PERIOD  = 3'd2;
	localparam logic [2:0] REG_RESET_LOW   = 3'd3;
	localparam logic [2:0] REG_LED_COUNT   = 3'd4;

	// register reset values
	localparam logic [7:0]  RST_ONE_HIGH   = 8'd9;
	localparam logic [7:0]  RST_ZERO_HIGH  = 8'd5;
	localparam logic [7:0]  RST_BIT_PERIOD = 8'd17;
	localparam logic [15:0] RST_RESET_LOW  = 16'd96;
	localparam logic [9:0]  RST_LED_COUNT  = 10'd144;

	localparam int QUEUE_DEPTH = 2;
	localparam int BITS_PER_BYTE = 8;

	// one classified byte waiting for the pulse generator
	typedef struct packed {
		logic [7:0] color;
		logic       frame_end;
	} work_t;

	// pulse timing registers seen by the pulse generator
	typedef struct packed {
		logic [7:0]  one_high;
		logic [7:0]  zero_high;
		logic [7:0]  bit_period;
		logic [15:0] reset_low;
	} timing_t;

endpackage

### sv/addressable_led_pulse_encoder_core.sv
// ----------------------------------------------------------------------------
// addressable_led_pulse_encoder_core
// colour bytes in, one-wire led bit pulses out
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata[7:0] colour byte
//  m_axis    out        tdata high/low ticks and bit, tuser reset flag, tlast
//  cfg       in         write of one timing or frame-length register
//
//  each byte gives eight pulse requests, one per cycle unless the output stalls;
//  a frame-closing byte adds a ninth (latch reset pulse); the generator loads the
//  next byte as it issues the last request; bytes queue two deep
//  reset clears counters, the queue and the output stage; registers go to defaults
//  a stalled output holds its request; the front keeps taking bytes until the queue fills
// ----------------------------------------------------------------------------
module addressable_led_pulse_encoder_core import alpe_pkg::*; #(
	parameter int BYTES_PER_LED   = 3,
	parameter int LED_INDEX_WIDTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] color_byte
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] high_ticks, [23:8] low_ticks, [24] data_bit
	output logic [0:0]  m_axis_tuser,   // [0] is_reset
	output logic        m_axis_tlast    // last request caused by the byte
);

	// configuration registers
	logic [7:0]  one_high_q;
	logic [7:0]  zero_high_q;
	logic [7:0]  bit_period_q;
	logic [15:0] reset_low_q;
	logic [9:0]  led_count_q;

	timing_t     timing;

	// front to queue and queue to back
	logic        push_valid;
	logic        push_ready;
	work_t       push_data;
	logic        pop_valid;
	logic        pop_ready;
	work_t       pop_data;

	// result fields
	logic [7:0]  out_high;
	logic [15:0] out_low;
	logic        out_bit;
	logic        out_is_reset;
	logic        out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_high_q   <= RST_ONE_HIGH;
			zero_high_q  <= RST_ZERO_HIGH;
			bit_period_q <= RST_BIT_PERIOD;
			reset_low_q  <= RST_RESET_LOW;
			led_count_q  <= RST_LED_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ONE_HIGH:   one_high_q   <= cfg_data[7:0];
				REG_ZERO_HIGH:  zero_high_q  <= cfg_data[7:0];
				REG_BIT_PERIOD: bit_period_q <= cfg_data[7:0];
				REG_RESET_LOW:  reset_low_q  <= cfg_data;
				REG_LED_COUNT:  led_count_q  <= cfg_data[9:0];
				default: ;  // unused indexes are ignored
			endcase
		end
	end

	assign timing.one_high   = one_high_q;
	assign timing.zero_high  = zero_high_q;
	assign timing.bit_period = bit_period_q;
	assign timing.reset_low  = reset_low_q;

	// byte and led counting, frame-end marking
	alpe_front #(
		.BYTES_PER_LED  (BYTES_PER_LED),
		.LED_INDEX_WIDTH(LED_INDEX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.led_count (led_count_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_color  (s_axis_tdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	// decoupling queue
	alpe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// pulse generation with registered output
	alpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.timing      (timing),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_high    (out_high),
		.out_low     (out_low),
		.out_bit     (out_bit),
		.out_is_reset(out_is_reset),
		.out_last    (out_last)
	);

	assign m_axis_tdata = {7'd0, out_bit, out_low, out_high};
	assign m_axis_tuser = out_is_reset;
	assign m_axis_tlast = out_last;

endmodule

### sv/alpe_front.sv
// ----------------------------------------------------------------------------
// alpe_front
// takes colour bytes and marks the one that closes a frame
// ----------------------------------------------------------------------------
module alpe_front import alpe_pkg::*; #(
	parameter int BYTES_PER_LED   = 3,
	parameter int LED_INDEX_WIDTH = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [9:0] led_count,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_color,
	output logic       push_valid,
	input  logic       push_ready,
	output work_t      push_data
);

	localparam int BW    = (BYTES_PER_LED > 2) ? $clog2(BYTES_PER_LED) : 1;
	localparam int CMP_W = (LED_INDEX_WIDTH + 1 > 11) ? LED_INDEX_WIDTH + 1 : 11;

	logic [BW-1:0]              byte_in_led_q;
	logic [LED_INDEX_WIDTH-1:0] led_index_q;
	logic [BW:0]                byte_inc;
	logic [LED_INDEX_WIDTH:0]   next_led;
	logic                       led_done;
	logic                       frame_end;
	logic                       accept;

	assign byte_inc  = {1'b0, byte_in_led_q} + 1'b1;
	assign led_done  = byte_inc >= (BW+1)'(BYTES_PER_LED);
	assign next_led  = {1'b0, led_index_q} + 1'b1;
	// overflow of the index ends the frame as well
	assign frame_end = led_done && ((CMP_W'(next_led) >= CMP_W'(led_count))
		|| next_led[LED_INDEX_WIDTH]);

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	assign push_data.color     = in_color;
	assign push_data.frame_end = frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_led_q <= '0;
			led_index_q   <= '0;
		end else if (accept) begin
			if (led_done) begin
				byte_in_led_q <= '0;
				led_index_q   <= frame_end ? '0 : next_led[LED_INDEX_WIDTH-1:0];
			end else begin
				byte_in_led_q <= byte_inc[BW-1:0];
			end
		end
	end

endmodule

### sv/alpe_queue.sv
// ----------------------------------------------------------------------------
// alpe_queue
// short queue between byte classification and pulse generation
// ----------------------------------------------------------------------------
module alpe_queue import alpe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_data
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	work_t         entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = count_q != CW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue empty with pointers apart");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (count_q < CW'(QUEUE_DEPTH)) || $past(push))
		else $error("queue still full after pop");

endmodule

### sv/alpe_back.sv
// ----------------------------------------------------------------------------
// alpe_back
// turns one queued byte into eight bit pulses and an optional latch reset
// ----------------------------------------------------------------------------
module alpe_back import alpe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  timing_t      timing,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  work_t        pop_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   out_high,
	output logic [15:0]  out_low,
	output logic         out_bit,
	output logic         out_is_reset,
	output logic         out_last
);

	logic       busy_q;
	logic [7:0] color_q;
	logic       fe_q;
	logic [3:0] cnt_q;
	logic       out_valid_q;
	logic       advance;
	logic       finish;
	logic       load;
	logic       is_rst;
	logic       cur_bit;
	logic [7:0] cur_high;
	logic [7:0] cur_low;

	assign advance = !out_valid_q || out_ready;
	assign is_rst  = (cnt_q == 4'(BITS_PER_BYTE));
	assign finish  = busy_q && advance && (fe_q ? is_rst : (cnt_q == 4'(BITS_PER_BYTE - 1)));
	assign load    = pop_valid && (!busy_q || finish);
	assign pop_ready = !busy_q || finish;

	// msb first
	assign cur_bit  = color_q[~cnt_q[2:0]];
	assign cur_high = cur_bit ? timing.one_high : timing.zero_high;
	assign cur_low  = (timing.bit_period > cur_high) ? timing.bit_period - cur_high : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (busy_q && advance) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			color_q <= pop_data.color;
			fe_q    <= pop_data.frame_end;
		end
		if (busy_q && advance) begin
			if (is_rst) begin
				out_high     <= 8'd0;
				out_low      <= timing.reset_low;
				out_bit      <= 1'b0;
				out_is_reset <= 1'b1;
				out_last     <= 1'b1;
			end else begin
				out_high     <= cur_high;
				out_low      <= {8'd0, cur_low};
				out_bit      <= cur_bit;
				out_is_reset <= 1'b0;
				out_last     <= !fe_q && (cnt_q == 4'(BITS_PER_BYTE - 1));
			end
		end
	end

	assign out_valid = out_valid_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= 4'(BITS_PER_BYTE)))
		else $error("bit counter out of range");
	a_rst_only_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !fe_q) |-> (cnt_q < 4'(BITS_PER_BYTE)))
		else $error("reset pulse for byte inside frame");
	a_reset_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_is_reset) |-> out_last)
		else $error("reset pulse not marked last");

endmodule
